// File: rtl/uv_sphere_mesh_generator_defines.svh
// ----------------------------------------------------------------------------
// uv sphere mesh generator assertion macros
// shared property forms for the sphere generator checks
// ----------------------------------------------------------------------------
`ifndef UV_SPHERE_MESH_GENERATOR_DEFINES_SVH
`define UV_SPHERE_MESH_GENERATOR_DEFINES_SVH

// same-cycle implication
`define SMG_ASSERT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SMG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/smg_pkg.sv
// ----------------------------------------------------------------------------
// smg_pkg
// types, widths and constants of the uv sphere mesh generator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package smg_pkg;

	// configuration
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SECTORS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STACKS  = 2'd2;

	localparam int MAX_STACKS  = 256;
	localparam int MAX_SECTORS = 256;
	localparam int MIN_STACKS  = 2;
	localparam int MIN_SECTORS = 3;

	localparam int RADIUS_W = 16;
	localparam int CNT_W    = 9;
	localparam logic [RADIUS_W-1:0] RADIUS_RST  = 16'd256;
	localparam logic [CNT_W-1:0]    SECTORS_RST = 9'd32;
	localparam logic [CNT_W-1:0]    STACKS_RST  = 9'd16;

	// stream payload
	localparam int IN_DATA_W = 8;
	localparam int COORD_W   = 17;
	localparam int IDX_W     = 17;
	localparam int TDATA_W   = 104;
	localparam int TUSER_W   = 2;
	localparam logic KIND_VERTEX   = 1'b0;
	localparam logic KIND_TRIANGLE = 1'b1;
	localparam int COORD_MAX = 65535;

	// angle and divider
	localparam int PHASE_W    = 24;
	localparam int DIV_NUM_W  = 33;
	localparam int DIV_STEPS  = 33;
	localparam int DIV_CNT_W  = 6;
	localparam int MUL_CYCLES = 5;

	// cordic
	localparam int COR_W       = 33;
	localparam int COR_STEPS   = 16;
	localparam int COR_IDX_W   = 4;
	localparam int CORDIC_GAIN = 652032874;
	localparam int HALF_PI_Q30 = 1686629713;
	localparam int HALF_PI_W   = 31;
	localparam int TRIG_W      = 18;
	localparam int TRIG_ONE    = 65536;

	// multiplier
	localparam int RING_W = 34;
	localparam int PROD_W = 52;

	typedef enum logic [1:0] {
		MUL_RING,
		MUL_Y,
		MUL_X,
		MUL_Z
	} smg_mul_t;

	typedef enum logic [1:0] {
		OUT_VERTEX,
		OUT_UPPER,
		OUT_LOWER
	} smg_out_t;

	typedef struct packed {
		logic                 div_load;
		logic                 div_sector;
		logic                 div_step;
		logic                 cor_load;
		logic                 cor_sector;
		logic                 cor_step;
		logic [COR_IDX_W-1:0] cor_iter;
		logic                 cor_store;
		logic                 mul_go;
		smg_mul_t             mul_sel;
		logic                 out_load;
		smg_out_t             out_sel;
		logic                 out_last;
		logic                 out_done;
		logic [CNT_W-1:0]     ring;
		logic [CNT_W-1:0]     col;
	} smg_cmd_t;

	typedef struct packed {
		logic out_free;
	} smg_stat_t;

	// arctangent of 2^-i in radians, q2.30
	function automatic logic signed [COR_W-1:0] cor_atan(input logic [COR_IDX_W-1:0] i);
		logic signed [COR_W-1:0] a;
		case (i)
			4'd0:    a = COR_W'(843314856);
			4'd1:    a = COR_W'(497837829);
			4'd2:    a = COR_W'(263043836);
			4'd3:    a = COR_W'(133525158);
			4'd4:    a = COR_W'(67021686);
			4'd5:    a = COR_W'(33543515);
			4'd6:    a = COR_W'(16775850);
			4'd7:    a = COR_W'(8388437);
			4'd8:    a = COR_W'(4194282);
			4'd9:    a = COR_W'(2097149);
			4'd10:   a = COR_W'(1048575);
			4'd11:   a = COR_W'(524287);
			4'd12:   a = COR_W'(262143);
			4'd13:   a = COR_W'(131071);
			4'd14:   a = COR_W'(65535);
			default: a = COR_W'(32767);
		endcase
		return a;
	endfunction

endpackage

// File: rtl/uv_sphere_mesh_generator.sv
// ----------------------------------------------------------------------------
// uv_sphere_mesh_generator
// a vertex request runs two angle divisions and two 16-step cordic passes on one
// shared unit, then the shared multiplier forms the ring, y, x and z products
// a triangle request emits one or two triangles; the output register frees the input
// one request is in flight at a time; a finished mesh answers with no result
// reset: radius 256, 32 sectors, 16 stacks, walk at the north pole, no clearing pass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uv_sphere_mesh_generator
	import smg_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // [0] restart
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [TDATA_W-1:0]    m_tdata,   // pos_x, pos_y, pos_z, corner_a, corner_b, corner_c
	output logic [TUSER_W-1:0]    m_tuser,   // [0] item_kind, [1] mesh_done
	output logic                  m_tlast,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	logic [RADIUS_W-1:0] radius_q;
	logic [CNT_W-1:0]    sectors_q;
	logic [CNT_W-1:0]    stacks_q;
	logic [CNT_W-1:0]    wr_count;
	logic                sectors_ok;
	logic                stacks_ok;
	logic                cfg_rewind;
	smg_cmd_t            cmd;
	smg_stat_t           stat;

	assign wr_count   = cfg_wdata[CNT_W-1:0];
	assign sectors_ok = (wr_count >= CNT_W'(MIN_SECTORS)) && (wr_count <= CNT_W'(MAX_SECTORS));
	assign stacks_ok  = (wr_count >= CNT_W'(MIN_STACKS)) && (wr_count <= CNT_W'(MAX_STACKS));
	// an accepted count write while idle starts the walk over
	assign cfg_rewind = cfg_we && (((cfg_index == CFG_SECTORS) && sectors_ok) ||
	                               ((cfg_index == CFG_STACKS) && stacks_ok));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q  <= RADIUS_RST;
			sectors_q <= SECTORS_RST;
			stacks_q  <= STACKS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_RADIUS: begin
					radius_q <= cfg_wdata[RADIUS_W-1:0];
				end
				CFG_SECTORS: begin
					if (sectors_ok) begin
						sectors_q <= wr_count;
					end
				end
				CFG_STACKS: begin
					if (stacks_ok) begin
						stacks_q <= wr_count;
					end
				end
				default: begin
				end
			endcase
		end
	end

	smg_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.restart    (s_tdata[0]),
		.cfg_rewind (cfg_rewind),
		.sectors    (sectors_q),
		.stacks     (stacks_q),
		.stat       (stat),
		.cmd        (cmd)
	);

	smg_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.radius   (radius_q),
		.sectors  (sectors_q),
		.stacks   (stacks_q),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

// File: rtl/smg_ctrl.sv
// ----------------------------------------------------------------------------
// smg_ctrl
// walk sequencer: grid and quad counters, per-request command sequence
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "uv_sphere_mesh_generator_defines.svh"

module smg_ctrl
	import smg_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic             restart,
	input  logic             cfg_rewind,
	input  logic [CNT_W-1:0] sectors,
	input  logic [CNT_W-1:0] stacks,
	input  smg_stat_t        stat,
	output smg_cmd_t         cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_DIV,
		ST_COR_LD,
		ST_COR,
		ST_COR_ST,
		ST_MUL,
		ST_EMIT_V,
		ST_EMIT_UP,
		ST_EMIT_LO
	} state_t;

	typedef enum logic [1:0] {
		PH_VERTEX,
		PH_TRI,
		PH_DONE
	} phase_t;

	state_t               state_q;
	phase_t               phase_q;
	logic [CNT_W-1:0]     ring_q;
	logic [CNT_W-1:0]     col_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 sector_pass_q;

	logic             accept;
	logic [CNT_W:0]   col_next;
	logic [CNT_W:0]   ring_next;
	logic             upper;
	logic             lower;
	logic             final_quad;

	assign s_tready   = (state_q == ST_IDLE);
	assign accept     = s_tvalid && s_tready;
	assign col_next   = {1'b0, col_q} + (CNT_W+1)'(1);
	assign ring_next  = {1'b0, ring_q} + (CNT_W+1)'(1);
	assign upper      = (ring_q != '0);
	assign lower      = (ring_next != {1'b0, stacks});
	assign final_quad = (ring_next >= {1'b0, stacks}) && (col_next >= {1'b0, sectors});

	always_comb begin
		cmd          = '0;
		cmd.mul_sel  = MUL_RING;
		cmd.out_sel  = OUT_VERTEX;
		cmd.ring     = ring_q;
		cmd.col      = col_q;
		cmd.cor_iter = cnt_q[COR_IDX_W-1:0];
		case (state_q)
			ST_START: begin
				cmd.div_load = (phase_q == PH_VERTEX);
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
			end
			ST_COR_LD: begin
				cmd.cor_load   = 1'b1;
				cmd.cor_sector = sector_pass_q;
			end
			ST_COR: begin
				cmd.cor_step = 1'b1;
			end
			ST_COR_ST: begin
				cmd.cor_store  = 1'b1;
				cmd.cor_sector = sector_pass_q;
				// sector angle division starts right behind the stack pass
				cmd.div_load   = !sector_pass_q;
				cmd.div_sector = 1'b1;
			end
			ST_MUL: begin
				cmd.mul_go  = (cnt_q < DIV_CNT_W'(MUL_CYCLES - 1));
				cmd.mul_sel = smg_mul_t'(cnt_q[1:0]);
			end
			ST_EMIT_V: begin
				cmd.out_load = stat.out_free;
				cmd.out_sel  = OUT_VERTEX;
				cmd.out_last = 1'b1;
			end
			ST_EMIT_UP: begin
				cmd.out_load = stat.out_free;
				cmd.out_sel  = OUT_UPPER;
				cmd.out_last = !lower;
				cmd.out_done = final_quad && !lower;
			end
			ST_EMIT_LO: begin
				cmd.out_load = stat.out_free;
				cmd.out_sel  = OUT_LOWER;
				cmd.out_last = 1'b1;
				cmd.out_done = final_quad;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			phase_q       <= PH_VERTEX;
			ring_q        <= '0;
			col_q         <= '0;
			cnt_q         <= '0;
			sector_pass_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (restart || cfg_rewind) begin
							phase_q <= PH_VERTEX;
							ring_q  <= '0;
							col_q   <= '0;
						end
						state_q <= ST_START;
					end else if (cfg_rewind) begin
						phase_q <= PH_VERTEX;
						ring_q  <= '0;
						col_q   <= '0;
					end
				end
				ST_START: begin
					cnt_q         <= '0;
					sector_pass_q <= 1'b0;
					case (phase_q)
						PH_VERTEX: state_q <= ST_DIV;
						PH_TRI:    state_q <= upper ? ST_EMIT_UP : ST_EMIT_LO;
						default:   state_q <= ST_IDLE;
					endcase
				end
				ST_DIV: begin
					cnt_q <= cnt_q + DIV_CNT_W'(1);
					if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_COR_LD;
					end
				end
				ST_COR_LD: begin
					cnt_q   <= '0;
					state_q <= ST_COR;
				end
				ST_COR: begin
					cnt_q <= cnt_q + DIV_CNT_W'(1);
					if (cnt_q == DIV_CNT_W'(COR_STEPS - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_COR_ST;
					end
				end
				ST_COR_ST: begin
					cnt_q <= '0;
					if (!sector_pass_q) begin
						sector_pass_q <= 1'b1;
						state_q       <= ST_DIV;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					cnt_q <= cnt_q + DIV_CNT_W'(1);
					if (cnt_q == DIV_CNT_W'(MUL_CYCLES - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_EMIT_V;
					end
				end
				ST_EMIT_V: begin
					if (stat.out_free) begin
						state_q <= ST_IDLE;
						if (col_next > {1'b0, sectors}) begin
							col_q <= '0;
							if (ring_next > {1'b0, stacks}) begin
								phase_q <= PH_TRI;
								ring_q  <= '0;
							end else begin
								ring_q <= ring_next[CNT_W-1:0];
							end
						end else begin
							col_q <= col_next[CNT_W-1:0];
						end
					end
				end
				ST_EMIT_UP, ST_EMIT_LO: begin
					if (stat.out_free) begin
						if (state_q == ST_EMIT_UP && lower) begin
							state_q <= ST_EMIT_LO;
						end else begin
							state_q <= ST_IDLE;
							if (col_next >= {1'b0, sectors}) begin
								col_q <= '0;
								if (ring_next >= {1'b0, stacks}) begin
									phase_q <= PH_DONE;
									ring_q  <= '0;
								end else begin
									ring_q <= ring_next[CNT_W-1:0];
								end
							end else begin
								col_q <= col_next[CNT_W-1:0];
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`SMG_ASSERT_NEXT(a_accept_starts, clk, arst_n, accept, state_q == ST_START, "accepted request did not start a walk step")
	`SMG_ASSERT(a_col_in_grid, clk, arst_n, phase_q == PH_VERTEX, col_q <= sectors, "vertex column beyond ring")
	`SMG_ASSERT(a_ring_in_quads, clk, arst_n, phase_q == PH_TRI, ring_q < stacks, "quad row beyond last stack")

endmodule

// File: rtl/smg_datapath.sv
// ----------------------------------------------------------------------------
// smg_datapath
// angle divider, shared cordic, shared multiplier and output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smg_datapath
	import smg_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  smg_cmd_t            cmd,
	output smg_stat_t           stat,
	input  logic [RADIUS_W-1:0] radius,
	input  logic [CNT_W-1:0]    sectors,
	input  logic [CNT_W-1:0]    stacks,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [TDATA_W-1:0]  m_tdata,
	output logic [TUSER_W-1:0]  m_tuser,
	output logic                m_tlast
);

	localparam int ZP_W = PHASE_W - 2 + HALF_PI_W;
	localparam logic [PHASE_W-1:0] QUARTER_TURN = PHASE_W'(1) << (PHASE_W - 2);
	localparam logic signed [COR_W-1:0]  RND14 = COR_W'(1) <<< 13;
	localparam logic signed [PROD_W-1:0] RND16 = PROD_W'(1) <<< 15;
	localparam logic signed [PROD_W-1:0] RND32 = PROD_W'(1) <<< 31;
	localparam logic signed [PROD_W-1:0] P_HI  = PROD_W'(COORD_MAX);
	localparam logic signed [PROD_W-1:0] P_LO  = -P_HI;
	localparam logic signed [COR_W-1:0]  T_HI  = COR_W'(TRIG_ONE);
	localparam logic signed [COR_W-1:0]  T_LO  = -T_HI;

	function automatic logic signed [TRIG_W-1:0] trig_clamp(input logic signed [COR_W-1:0] v);
		logic signed [COR_W-1:0] r;
		r = (v + RND14) >>> 14;
		if (r > T_HI) begin
			r = T_HI;
		end else if (r < T_LO) begin
			r = T_LO;
		end
		return r[TRIG_W-1:0];
	endfunction

	function automatic logic signed [COORD_W-1:0] coord_sat(input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W-1:0] r;
		r = v;
		if (r > P_HI) begin
			r = P_HI;
		end else if (r < P_LO) begin
			r = P_LO;
		end
		return r[COORD_W-1:0];
	endfunction

	// restoring divider, quotient shifts in where the numerator shifts out
	logic [DIV_NUM_W-1:0] num_q;
	logic [CNT_W-1:0]     divisor_q;
	logic [CNT_W-1:0]     rem_q;
	logic [CNT_W:0]       trial;
	logic                 trial_ge;
	logic [CNT_W:0]       trial_diff;

	assign trial      = {rem_q, num_q[DIV_NUM_W-1]};
	assign trial_ge   = (trial >= {1'b0, divisor_q});
	assign trial_diff = trial - {1'b0, divisor_q};

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			rem_q <= '0;
			if (cmd.div_sector) begin
				divisor_q <= sectors;
				num_q <= (DIV_NUM_W'(cmd.col) << PHASE_W) + DIV_NUM_W'(sectors >> 1);
			end else begin
				divisor_q <= stacks;
				num_q <= (DIV_NUM_W'(cmd.ring) << (PHASE_W - 1)) + DIV_NUM_W'(stacks >> 1);
			end
		end else if (cmd.div_step) begin
			rem_q <= trial_ge ? trial_diff[CNT_W-1:0] : trial[CNT_W-1:0];
			num_q <= {num_q[DIV_NUM_W-2:0], trial_ge};
		end
	end

	// cordic rotation
	logic [PHASE_W-1:0]      phase;
	logic [ZP_W-1:0]         zprod;
	logic signed [COR_W-1:0] cx_q, cy_q, cz_q;
	logic [1:0]              quad_q;
	logic signed [COR_W-1:0] dx, dy, atan_i;
	logic signed [TRIG_W-1:0] cos_r, sin_r, cos_q4, sin_q4;
	logic signed [TRIG_W-1:0] cs_q, ss_q, ct_q, st_q;

	assign phase  = cmd.cor_sector ? num_q[PHASE_W-1:0] : (QUARTER_TURN - num_q[PHASE_W-1:0]);
	assign zprod  = ZP_W'(phase[PHASE_W-3:0]) * ZP_W'(HALF_PI_Q30);
	assign dx     = cy_q >>> cmd.cor_iter;
	assign dy     = cx_q >>> cmd.cor_iter;
	assign atan_i = cor_atan(cmd.cor_iter);
	assign cos_r  = trig_clamp(cx_q);
	assign sin_r  = trig_clamp(cy_q);

	always_comb begin
		case (quad_q)
			2'd0: begin
				cos_q4 = cos_r;
				sin_q4 = sin_r;
			end
			2'd1: begin
				cos_q4 = -sin_r;
				sin_q4 = cos_r;
			end
			2'd2: begin
				cos_q4 = -cos_r;
				sin_q4 = -sin_r;
			end
			default: begin
				cos_q4 = sin_r;
				sin_q4 = -cos_r;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.cor_load) begin
			quad_q <= phase[PHASE_W-1:PHASE_W-2];
			cx_q   <= COR_W'(CORDIC_GAIN);
			cy_q   <= '0;
			cz_q   <= COR_W'(zprod[ZP_W-1:PHASE_W-2]);
		end else if (cmd.cor_step) begin
			if (!cz_q[COR_W-1]) begin
				cx_q <= cx_q - dx;
				cy_q <= cy_q + dy;
				cz_q <= cz_q - atan_i;
			end else begin
				cx_q <= cx_q + dx;
				cy_q <= cy_q - dy;
				cz_q <= cz_q + atan_i;
			end
		end
		if (cmd.cor_store) begin
			if (cmd.cor_sector) begin
				ct_q <= cos_q4;
				st_q <= sin_q4;
			end else begin
				cs_q <= cos_q4;
				ss_q <= sin_q4;
			end
		end
	end

	// shared multiplier, one product per cycle, scaled in the following cycle
	logic signed [RING_W-1:0] mul_a;
	logic signed [TRIG_W-1:0] mul_b;
	logic signed [PROD_W-1:0] prod_s1;
	smg_mul_t                 sel_s1;
	logic                     vld_s1;
	logic signed [RING_W-1:0] ring_q;
	logic signed [COORD_W-1:0] px_q, py_q, pz_q;
	logic signed [PROD_W-1:0] rnd16, rnd32;

	always_comb begin
		case (cmd.mul_sel)
			MUL_RING: begin
				mul_a = $signed(RING_W'(radius));
				mul_b = cs_q;
			end
			MUL_Y: begin
				mul_a = $signed(RING_W'(radius));
				mul_b = ss_q;
			end
			MUL_X: begin
				mul_a = ring_q;
				mul_b = ct_q;
			end
			default: begin
				mul_a = ring_q;
				mul_b = st_q;
			end
		endcase
	end

	assign rnd16 = (prod_s1 + RND16) >>> 16;
	assign rnd32 = (prod_s1 + RND32) >>> 32;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= cmd.mul_go;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_go) begin
			prod_s1 <= PROD_W'(mul_a) * PROD_W'(mul_b);
			sel_s1  <= cmd.mul_sel;
		end
		if (vld_s1) begin
			case (sel_s1)
				MUL_RING: ring_q <= prod_s1[RING_W-1:0];
				MUL_Y:    py_q   <= coord_sat(rnd16);
				MUL_X:    px_q   <= coord_sat(rnd32);
				default:  pz_q   <= coord_sat(rnd32);
			endcase
		end
	end

	// quad corner indices
	logic [IDX_W-1:0] per_ring, tl, tr, bl, br;

	assign per_ring = IDX_W'(sectors) + IDX_W'(1);
	assign tl       = IDX_W'(cmd.ring) * per_ring + IDX_W'(cmd.col);
	assign tr       = tl + IDX_W'(1);
	assign bl       = tl + per_ring;
	assign br       = bl + IDX_W'(1);

	// output register
	logic                     out_vld_q;
	logic                     kind_q, last_q, done_q;
	logic signed [COORD_W-1:0] ox_q, oy_q, oz_q;
	logic [IDX_W-1:0]         oa_q, ob_q, oc_q;

	assign stat.out_free = !out_vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			last_q <= cmd.out_last;
			done_q <= cmd.out_done;
			case (cmd.out_sel)
				OUT_VERTEX: begin
					kind_q <= KIND_VERTEX;
					ox_q   <= px_q;
					oy_q   <= py_q;
					oz_q   <= pz_q;
					oa_q   <= '0;
					ob_q   <= '0;
					oc_q   <= '0;
				end
				OUT_UPPER: begin
					kind_q <= KIND_TRIANGLE;
					ox_q   <= '0;
					oy_q   <= '0;
					oz_q   <= '0;
					oa_q   <= tl;
					ob_q   <= tr;
					oc_q   <= bl;
				end
				default: begin
					kind_q <= KIND_TRIANGLE;
					ox_q   <= '0;
					oy_q   <= '0;
					oz_q   <= '0;
					oa_q   <= tr;
					ob_q   <= br;
					oc_q   <= bl;
				end
			endcase
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {2'b00, oc_q, ob_q, oa_q, oz_q, oy_q, ox_q};
	assign m_tuser  = {done_q, kind_q};
	assign m_tlast  = last_q;

endmodule

// File: sim/uv_sphere_mesh_generator_tb.sv
// ----------------------------------------------------------------------------
// uv_sphere_mesh_generator_tb
// drives request ticks, some with restart, into the sphere tessellator over many mesh settings,
// predicts every vertex and triangle with a bit-exact cordic model of its own
// and compares the output stream field by field under random backpressure
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uv_sphere_mesh_generator_tb;
	import smg_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 150;
	localparam int HOLD_CYCLES    = 800;

	typedef enum logic [1:0] {
		WALK_VERTS,
		WALK_QUADS,
		WALK_DONE
	} walk_t;

	typedef struct {
		logic               kind;
		logic [COORD_W-1:0] x, y, z;
		logic [IDX_W-1:0]   a, b, c;
		logic               last, done;
	} mesh_item_t;

	class mesh_tracker;
		logic [RADIUS_W-1:0] radius;
		int                  sectors, stacks, ring_idx, col_idx;
		walk_t               walk;
		mesh_item_t          awaited[$];
		int                  errors;

		function new();
			radius  = RADIUS_RST;
			sectors = SECTORS_RST;
			stacks  = STACKS_RST;
			errors  = 0;
			rewind();
		endfunction

		function void rewind();
			walk     = WALK_VERTS;
			ring_idx = 0;
			col_idx  = 0;
		endfunction

		function longint round_shift(longint v, int sh);
			return (v + (longint'(1) <<< (sh - 1))) >>> sh;
		endfunction

		function longint saturate(longint v, longint lim);
			if (v > lim) return lim;
			if (v < -lim) return -lim;
			return v;
		endfunction

		// phase in 2^-24 turns, results in q.16
		function void cordic_cos_sin(input longint phase, output longint c16, output longint s16);
			longint angle_tab [16];
			longint q, x, y, z, dx, dy, c, s;
			int     quad;
			angle_tab = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
				16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
				131071, 65535, 32767};
			quad = int'((phase >> 22) & 3);
			q = phase & 64'h3FFFFF;
			z = (q * longint'(HALF_PI_Q30)) >> 22;
			x = longint'(CORDIC_GAIN);
			y = 0;
			for (int i = 0; i < 16; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x = x - dx;
					y = y + dy;
					z = z - angle_tab[i];
				end else begin
					x = x + dx;
					y = y - dy;
					z = z + angle_tab[i];
				end
			end
			c = saturate(round_shift(x, 14), longint'(TRIG_ONE));
			s = saturate(round_shift(y, 14), longint'(TRIG_ONE));
			case (quad)
				0: begin
					c16 = c;
					s16 = s;
				end
				1: begin
					c16 = -s;
					s16 = c;
				end
				2: begin
					c16 = -c;
					s16 = -s;
				end
				default: begin
					c16 = s;
					s16 = -c;
				end
			endcase
		endfunction

		function void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			int v;
			v = int'(val[CNT_W-1:0]);
			case (idx)
				CFG_RADIUS: radius = val;
				CFG_SECTORS: begin
					if (v >= MIN_SECTORS && v <= MAX_SECTORS) begin
						sectors = v;
						rewind();
					end
				end
				CFG_STACKS: begin
					if (v >= MIN_STACKS && v <= MAX_STACKS) begin
						stacks = v;
						rewind();
					end
				end
				default: ;
			endcase
		endfunction

		function void push(logic kind, longint px, longint py, longint pz,
			longint ca, longint cb, longint cc, bit last, bit done);
			mesh_item_t r;
			r.kind = kind;
			r.x    = px[COORD_W-1:0];
			r.y    = py[COORD_W-1:0];
			r.z    = pz[COORD_W-1:0];
			r.a    = ca[IDX_W-1:0];
			r.b    = cb[IDX_W-1:0];
			r.c    = cc[IDX_W-1:0];
			r.last = last;
			r.done = done;
			awaited.insert(awaited.size(), r);
		endfunction

		// one accepted request: advance the walk and queue what it produces
		function void note_tick(bit restart);
			longint sp, tp, cs, ss, ct, st, ring_r, px, py, pz;
			int     per_ring, tl;
			bit     upper, lower, last_quad;
			if (restart) rewind();
			case (walk)
				WALK_VERTS: begin
					sp = (64'sd4194304 - (longint'(ring_idx) * 8388608 + stacks / 2) / stacks)
						& 64'hFFFFFF;
					tp = ((longint'(col_idx) * 16777216 + sectors / 2) / sectors) & 64'hFFFFFF;
					cordic_cos_sin(sp, cs, ss);
					cordic_cos_sin(tp, ct, st);
					py = saturate(round_shift(longint'(radius) * ss, 16), longint'(COORD_MAX));
					ring_r = longint'(radius) * cs;
					px = saturate(round_shift(ring_r * ct, 32), longint'(COORD_MAX));
					pz = saturate(round_shift(ring_r * st, 32), longint'(COORD_MAX));
					push(KIND_VERTEX, px, py, pz, 64'sd0, 64'sd0, 64'sd0, 1'b1, 1'b0);
					col_idx++;
					if (col_idx > sectors) begin
						col_idx = 0;
						ring_idx++;
						if (ring_idx > stacks) begin
							walk = WALK_QUADS;
							ring_idx = 0;
						end
					end
				end
				WALK_QUADS: begin
					per_ring  = sectors + 1;
					tl        = ring_idx * per_ring + col_idx;
					upper     = ring_idx != 0;
					lower     = ring_idx + 1 != stacks;
					last_quad = (ring_idx + 1 >= stacks) && (col_idx + 1 >= sectors);
					if (upper)
						push(KIND_TRIANGLE, 64'sd0, 64'sd0, 64'sd0, longint'(tl),
							longint'(tl + 1), longint'(tl + per_ring),
							!lower, last_quad && !lower);
					if (lower)
						push(KIND_TRIANGLE, 64'sd0, 64'sd0, 64'sd0, longint'(tl + 1),
							longint'(tl + per_ring + 1), longint'(tl + per_ring),
							1'b1, last_quad);
					col_idx++;
					if (col_idx >= sectors) begin
						col_idx = 0;
						ring_idx++;
						if (ring_idx >= stacks) begin
							walk = WALK_DONE;
							ring_idx = 0;
						end
					end
				end
				default: ;
			endcase
		endfunction

		function void compare(string name, longint want, longint got);
			if (want != got) begin
				$error("%s expected %0d got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(mesh_item_t got);
			mesh_item_t want;
			if (awaited.size() == 0) begin
				$error("result arrived with no request outstanding");
				errors++;
				return;
			end
			want = awaited.pop_front();
			compare("item_kind", longint'(want.kind), longint'(got.kind));
			compare("pos_x", longint'($signed(want.x)), longint'($signed(got.x)));
			compare("pos_y", longint'($signed(want.y)), longint'($signed(got.y)));
			compare("pos_z", longint'($signed(want.z)), longint'($signed(got.z)));
			compare("corner_a", longint'(want.a), longint'(got.a));
			compare("corner_b", longint'(want.b), longint'(got.b));
			compare("corner_c", longint'(want.c), longint'(got.c));
			compare("run_last", longint'(want.last), longint'(got.last));
			compare("mesh_done", longint'(want.done), longint'(got.done));
		endfunction
	endclass

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [TDATA_W-1:0]    m_tdata;
	logic [TUSER_W-1:0]    m_tuser;
	logic                  m_tlast;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	mesh_tracker tracker;
	int          src_idle   = 30;
	int          sink_idle  = 57;
	int          ticks_sent = 0;
	bit          hold_req   = 1'b0;
	int          quiet      = 0;

	uv_sphere_mesh_generator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #10 clk = ~clk;

	// result side: check, then pick next ready
	always @(posedge clk) begin : sink
		mesh_item_t got;
		int         hold_left;
		bit         hold_taken;
		if (arst_n && m_tvalid && m_tready) begin
			got.kind = m_tuser[0];
			got.done = m_tuser[1];
			got.last = m_tlast;
			got.x    = m_tdata[0 +: COORD_W];
			got.y    = m_tdata[COORD_W +: COORD_W];
			got.z    = m_tdata[2*COORD_W +: COORD_W];
			got.a    = m_tdata[3*COORD_W +: IDX_W];
			got.b    = m_tdata[3*COORD_W+IDX_W +: IDX_W];
			got.c    = m_tdata[3*COORD_W+2*IDX_W +: IDX_W];
			tracker.check_result(got);
		end
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else if (hold_req && !hold_taken) begin
			// long back-pressure so the block fills and stalls its input
			hold_taken = 1'b1;
			hold_left  = HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= sink_idle);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WATCHDOG_LIMIT) begin
			$display("uv_sphere_mesh_generator test failed");
			$finish;
		end
	end

	task automatic send_tick(bit restart);
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_DATA_W'(restart);
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		tracker.note_tick(restart);
		ticks_sent++;
	endtask

	// sender pauses until every expected result is back, then lets the block go idle
	task automatic settle();
		s_tvalid <= 1'b0;
		while (tracker.awaited.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.apply_write(idx, val);
		@(posedge clk);
	endtask

	// whole meshes with random content and an occasional stray restart or bad write
	task automatic run_meshes(int src_pct, int sink_pct, int quota, bit with_hold);
		int goal, len;
		bit counts_set;
		src_idle  = src_pct;
		sink_idle = sink_pct;
		goal = ticks_sent + quota;
		while (ticks_sent < goal) begin
			settle();
			counts_set = 1'b0;
			if ($urandom_range(3) != 0) begin
				write_reg(CFG_SECTORS, CFG_DATA_W'(($urandom_range(9) == 0) ?
					$urandom_range(24, 9) : $urandom_range(8, 3)));
				counts_set = 1'b1;
			end
			if ($urandom_range(3) != 0) begin
				write_reg(CFG_STACKS, CFG_DATA_W'(($urandom_range(9) == 0) ?
					$urandom_range(12, 7) : $urandom_range(6, 2)));
				counts_set = 1'b1;
			end
			case ($urandom_range(7))
				0: write_reg(CFG_RADIUS, '0);
				1: write_reg(CFG_RADIUS, '1);
				2, 3: write_reg(CFG_RADIUS, CFG_DATA_W'($urandom));
				default: ;
			endcase
			case ($urandom_range(9))
				0: write_reg(CFG_SECTORS, CFG_DATA_W'($urandom_range(1) ?
					$urandom_range(2, 0) : $urandom_range(511, 257)));
				1: write_reg(CFG_STACKS, CFG_DATA_W'($urandom_range(1) ?
					$urandom_range(1, 0) : $urandom_range(511, 257)));
				2: write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
				default: ;
			endcase
			if (with_hold) hold_req = 1'b1;
			len = (tracker.stacks + 1) * (tracker.sectors + 1)
				+ tracker.stacks * tracker.sectors + $urandom_range(3, 0);
			for (int k = 0; k < len; k++) begin
				if (k == len / 2 && $urandom_range(4) == 0) begin
					settle();
					write_reg(CFG_RADIUS, CFG_DATA_W'($urandom));
				end
				send_tick((k == 0 && !counts_set) || $urandom_range(99) == 0);
			end
		end
	endtask

	initial begin
		tracker = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings from the north pole
		send_tick(1'b0);
		send_tick(1'b0);
		// radius change keeps the walk going
		settle();
		write_reg(CFG_RADIUS, '1);
		send_tick(1'b0);
		settle();
		write_reg(CFG_RADIUS, '0);
		send_tick(1'b0);
		// largest grid, count writes rewind
		settle();
		write_reg(CFG_SECTORS, CFG_DATA_W'(MAX_SECTORS));
		write_reg(CFG_STACKS, CFG_DATA_W'(MAX_STACKS));
		write_reg(CFG_RADIUS, '1);
		send_tick(1'b0);
		send_tick(1'b0);
		// rejected counts and an unused index leave the walk alone
		settle();
		write_reg(CFG_SECTORS, 16'd2);
		write_reg(CFG_SECTORS, 16'd257);
		write_reg(CFG_STACKS, 16'd1);
		write_reg(CFG_STACKS, 16'd0);
		write_reg(CFG_STACKS, 16'h01FF);
		write_reg(CFG_SPARE, 16'hFFFF);
		send_tick(1'b0);
		// smallest mesh end to end, upper bits of the count write drop off
		settle();
		write_reg(CFG_SECTORS, 16'hFE03);
		write_reg(CFG_STACKS, CFG_DATA_W'(MIN_STACKS));
		write_reg(CFG_RADIUS, RADIUS_RST);
		repeat (19) send_tick(1'b0);
		send_tick(1'b1);

		run_meshes(30, 57, 270, 1'b0);
		run_meshes(57, 30, 270, 1'b0);
		run_meshes(0, 0, 270, 1'b1);
		settle();

		if (tracker.errors == 0 && tracker.awaited.size() == 0)
			$display("uv_sphere_mesh_generator test passed");
		else
			$display("uv_sphere_mesh_generator test failed");
		$finish;
	end

endmodule
